/* hw/rtl/npc_pkg.sv */
package npc_pkg;

    localparam int PALETTE_DEPTH = 256;

    localparam int LABEL_W    = 16;
    localparam int COLOR_W    = 24;
    localparam int SLOT_W     = 8;
    localparam int DIST_OUT_W = 40;

    localparam int COEF_W = 15;
    localparam int DIFF_W = 9;
    localparam int COMP_W = 24;
    localparam int MAG_W  = 23;
    localparam int SQ_W   = 46;
    localparam int DIST_W = 48;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        COMP_Y = 2'd0,
        COMP_U = 2'd1,
        COMP_V = 2'd2
    } t_comp;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [COLOR_W-1:0] color;
    } t_entry;

    typedef struct packed {
        logic signed [COEF_W-1:0] cr;
        logic signed [COEF_W-1:0] cg;
        logic signed [COEF_W-1:0] cb;
    } t_coef_row;

    typedef struct packed {
        logic  valid;
        t_comp comp;
        logic  last;
    } t_dist_ctl;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [DIST_W-1:0] dsq;
        t_entry            entry;
    } t_dist_res;

    // BT.601 RGB to YUV, Q1.14
    function automatic t_coef_row coef_row(input t_comp comp);
        t_coef_row row;
        case (comp)
            COMP_Y: row = '{cr: 15'sd4899,   cg: 15'sd9617,   cb: 15'sd1868};
            COMP_U: row = '{cr: -15'sd2411,  cg: -15'sd4733,  cb: 15'sd7143};
            COMP_V: row = '{cr: 15'sd10076,  cg: -15'sd8438,  cb: -15'sd1639};
            default: row = '0;
        endcase
        return row;
    endfunction

endpackage

/* hw/rtl/npc_if.sv */
interface npc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] entry_label;
    logic [23:0] entry_color;
    logic [23:0] query_color;

    modport source (output valid, mode, entry_label, entry_color, query_color, input ready);
    modport sink   (input valid, mode, entry_label, entry_color, query_color, output ready);
endinterface

interface npc_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] nearest_label;
    logic [23:0] nearest_color;
    logic [7:0]  nearest_slot;
    logic [39:0] distance_squared;

    modport source (output valid, found, nearest_label, nearest_color, nearest_slot,
                    distance_squared, input ready);
    modport sink   (input valid, found, nearest_label, nearest_color, nearest_slot,
                    distance_squared, output ready);
endinterface

/* hw/rtl/nearest_palette_color_yuv.sv */
// Nearest palette color search in YUV space.
// Input channel i_in carries one command per transfer: clear the palette,
// append a labeled RGB entry (dropped when the palette is full), query the
// entry nearest to an RGB color, or no operation. Only a query produces a
// result transfer on o_out: found, label, color, slot and squared distance
// (Q12.28, saturated to 40 bits). An empty palette answers found=0, all zero.
// Clear, append and no operation keep the block idle. A query reads the
// palette entry by entry: one shared distance unit evaluates one YUV
// component per cycle, Y, U and V in turn for each entry, and each result
// passes the palette RAM read, the distance pipeline and the compare.
// i_in.ready is low while a query runs. A held result does not block clear
// or append commands; a finished query waits until the output register
// frees. Reset empties the palette and drops any pending result.
module nearest_palette_color_yuv #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    npc_in_if.sink      i_in,
    npc_out_if.source   o_out
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW = $clog2(PALETTE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT,
        S_DONE
    } t_state;

    t_state                           r_state, n_state;
    logic [CW-1:0]                    r_entry_count, n_entry_count;
    logic [AW-1:0]                    r_addr, n_addr;
    npc_pkg::t_comp                   r_phase, n_phase;
    logic [npc_pkg::COLOR_W-1:0]      r_qcol, n_qcol;
    logic                             r_found, n_found;
    logic [npc_pkg::DIST_W-1:0]       r_best_d, n_best_d;
    npc_pkg::t_entry                  r_best_entry, n_best_entry;
    logic [AW-1:0]                    r_best_idx, n_best_idx;

    logic                             r_out_valid, n_out_valid;
    logic                             r_out_found, n_out_found;
    logic [npc_pkg::LABEL_W-1:0]      r_out_label, n_out_label;
    logic [npc_pkg::COLOR_W-1:0]      r_out_color, n_out_color;
    logic [npc_pkg::SLOT_W-1:0]       r_out_slot, n_out_slot;
    logic [npc_pkg::DIST_OUT_W-1:0]   r_out_dist, n_out_dist;

    npc_pkg::t_dist_ctl               w_iss;
    npc_pkg::t_dist_ctl               r_iss;
    logic [AW-1:0]                    r_iss_idx;
    npc_pkg::t_entry                  w_wdata;
    npc_pkg::t_entry                  w_rdata;
    npc_pkg::t_dist_res               w_res;
    logic [AW-1:0]                    w_res_idx;
    logic                             w_ram_we;
    logic                             w_last_addr;

    assign w_wdata.label = i_in.entry_label;
    assign w_wdata.color = i_in.entry_color;

    npc_ram #(
        .WIDTH ($bits(npc_pkg::t_entry)),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_entry_count[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    npc_dist #(
        .IDX_W (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_iss),
        .i_idx   (r_iss_idx),
        .i_query (r_qcol),
        .i_entry (w_rdata),
        .o_res   (w_res),
        .o_idx   (w_res_idx)
    );

    assign w_last_addr = (CW'(r_addr) == (r_entry_count - CW'(1)));

    always_comb begin
        w_iss.valid = (r_state == S_RUN);
        w_iss.comp  = r_phase;
        w_iss.last  = (r_phase == npc_pkg::COMP_V) && w_last_addr;
    end

    always_comb begin
        n_state       = r_state;
        n_entry_count = r_entry_count;
        n_addr        = r_addr;
        n_phase       = r_phase;
        n_qcol        = r_qcol;
        n_found       = r_found;
        n_best_d      = r_best_d;
        n_best_entry  = r_best_entry;
        n_best_idx    = r_best_idx;
        n_out_valid   = r_out_valid;
        n_out_found   = r_out_found;
        n_out_label   = r_out_label;
        n_out_color   = r_out_color;
        n_out_slot    = r_out_slot;
        n_out_dist    = r_out_dist;
        w_ram_we      = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (npc_pkg::t_mode'(i_in.mode))
                        npc_pkg::MODE_CLEAR: begin
                            n_entry_count = '0;
                        end
                        npc_pkg::MODE_APPEND: begin
                            if (r_entry_count < CW'(PALETTE_DEPTH)) begin
                                w_ram_we      = 1'b1;
                                n_entry_count = r_entry_count + CW'(1);
                            end
                        end
                        npc_pkg::MODE_QUERY: begin
                            n_qcol  = i_in.query_color;
                            n_addr  = '0;
                            n_phase = npc_pkg::COMP_Y;
                            if (r_entry_count == '0) begin
                                n_found      = 1'b0;
                                n_best_d     = '0;
                                n_best_entry = '0;
                                n_best_idx   = '0;
                                n_state      = S_DONE;
                            end else begin
                                n_found = 1'b1;
                                n_state = S_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                case (r_phase)
                    npc_pkg::COMP_Y: n_phase = npc_pkg::COMP_U;
                    npc_pkg::COMP_U: n_phase = npc_pkg::COMP_V;
                    default: begin
                        n_phase = npc_pkg::COMP_Y;
                        if (w_last_addr) begin
                            n_state = S_WAIT;
                        end else begin
                            n_addr = r_addr + AW'(1);
                        end
                    end
                endcase
            end
            S_WAIT: ;
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_label = r_best_entry.label;
                    n_out_color = r_best_entry.color;
                    n_out_slot  = npc_pkg::SLOT_W'(r_best_idx);
                    n_out_dist  = (|r_best_d[npc_pkg::DIST_W-1:npc_pkg::DIST_OUT_W])
                                ? '1 : r_best_d[npc_pkg::DIST_OUT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // first minimum wins
        if (w_res.valid) begin
            if ((w_res_idx == '0) || (w_res.dsq < r_best_d)) begin
                n_best_d     = w_res.dsq;
                n_best_entry = w_res.entry;
                n_best_idx   = w_res_idx;
            end
            if (w_res.last) begin
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
            r_iss.valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_entry_count <= n_entry_count;
            r_out_valid   <= n_out_valid;
            r_iss.valid   <= w_iss.valid;
        end
        r_addr       <= n_addr;
        r_phase      <= n_phase;
        r_qcol       <= n_qcol;
        r_found      <= n_found;
        r_best_d     <= n_best_d;
        r_best_entry <= n_best_entry;
        r_best_idx   <= n_best_idx;
        r_out_found  <= n_out_found;
        r_out_label  <= n_out_label;
        r_out_color  <= n_out_color;
        r_out_slot   <= n_out_slot;
        r_out_dist   <= n_out_dist;
        r_iss.comp   <= w_iss.comp;
        r_iss.last   <= w_iss.last;
        r_iss_idx    <= r_addr;
    end

    assign i_in.ready             = (r_state == S_IDLE);
    assign o_out.valid            = r_out_valid;
    assign o_out.found            = r_out_found;
    assign o_out.nearest_label    = r_out_label;
    assign o_out.nearest_color    = r_out_color;
    assign o_out.nearest_slot     = r_out_slot;
    assign o_out.distance_squared = r_out_dist;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= CW'(PALETTE_DEPTH))
        else $error("palette count beyond depth");

    a_res_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> (r_state == S_RUN || r_state == S_WAIT))
        else $error("distance result outside a query");

    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (CW'(r_addr) < r_entry_count))
        else $error("palette read beyond stored entries");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside done state");

endmodule

/* hw/rtl/npc_ram.sv */
module npc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/npc_dist.sv */
module npc_dist #(
    parameter int IDX_W = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  npc_pkg::t_dist_ctl                 i_ctl,
    input  logic [IDX_W-1:0]                   i_idx,
    input  logic [npc_pkg::COLOR_W-1:0]        i_query,
    input  npc_pkg::t_entry                    i_entry,
    output npc_pkg::t_dist_res                 o_res,
    output logic [IDX_W-1:0]                   o_idx
);

    npc_pkg::t_coef_row                  w_coef;
    logic signed [npc_pkg::DIFF_W-1:0]   w_dr;
    logic signed [npc_pkg::DIFF_W-1:0]   w_dg;
    logic signed [npc_pkg::DIFF_W-1:0]   w_db;
    logic signed [npc_pkg::COMP_W-1:0]   w_c;
    logic [npc_pkg::MAG_W-1:0]           w_mag;
    logic [npc_pkg::COMP_W-1:0]          w_neg;

    npc_pkg::t_dist_ctl                  r_s1_ctl;
    logic signed [npc_pkg::COMP_W-1:0]   r_s1_c;
    logic [IDX_W-1:0]                    r_s1_idx;
    npc_pkg::t_entry                     r_s1_entry;

    npc_pkg::t_dist_ctl                  r_s2_ctl;
    logic [npc_pkg::SQ_W-1:0]            r_s2_sq;
    logic [IDX_W-1:0]                    r_s2_idx;
    npc_pkg::t_entry                     r_s2_entry;

    logic [npc_pkg::DIST_W-1:0]          r_acc;
    npc_pkg::t_dist_res                  r_res;
    logic [IDX_W-1:0]                    r_res_idx;

    // component of query minus entry in YUV, units of 2^-14, and magnitude of the stage-1 component
    always_comb begin
        w_coef = npc_pkg::coef_row(i_ctl.comp);
        w_dr = $signed({1'b0, i_query[23:16]}) - $signed({1'b0, i_entry.color[23:16]});
        w_dg = $signed({1'b0, i_query[15:8]})  - $signed({1'b0, i_entry.color[15:8]});
        w_db = $signed({1'b0, i_query[7:0]})   - $signed({1'b0, i_entry.color[7:0]});
        w_c  = npc_pkg::COMP_W'(w_coef.cr) * npc_pkg::COMP_W'(w_dr)
             + npc_pkg::COMP_W'(w_coef.cg) * npc_pkg::COMP_W'(w_dg)
             + npc_pkg::COMP_W'(w_coef.cb) * npc_pkg::COMP_W'(w_db);
        w_neg = -r_s1_c;
        w_mag = r_s1_c[npc_pkg::COMP_W-1] ? w_neg[npc_pkg::MAG_W-1:0]
                                          : r_s1_c[npc_pkg::MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.valid <= 1'b0;
            r_s2_ctl.valid <= 1'b0;
            r_res.valid    <= 1'b0;
        end else begin
            r_s1_ctl.valid <= i_ctl.valid;
            r_s2_ctl.valid <= r_s1_ctl.valid;
            r_res.valid    <= r_s2_ctl.valid && (r_s2_ctl.comp == npc_pkg::COMP_V);
        end
        r_s1_ctl.comp <= i_ctl.comp;
        r_s1_ctl.last <= i_ctl.last;
        r_s1_c        <= w_c;
        r_s1_idx      <= i_idx;
        r_s1_entry    <= i_entry;

        r_s2_ctl.comp <= r_s1_ctl.comp;
        r_s2_ctl.last <= r_s1_ctl.last;
        r_s2_sq       <= npc_pkg::SQ_W'(w_mag) * npc_pkg::SQ_W'(w_mag);
        r_s2_idx      <= r_s1_idx;
        r_s2_entry    <= r_s1_entry;

        if (r_s2_ctl.comp == npc_pkg::COMP_Y) begin
            r_acc <= npc_pkg::DIST_W'(r_s2_sq);
        end else begin
            r_acc <= r_acc + npc_pkg::DIST_W'(r_s2_sq);
        end
        r_res.last  <= r_s2_ctl.last;
        r_res.dsq   <= r_acc + npc_pkg::DIST_W'(r_s2_sq);
        r_res.entry <= r_s2_entry;
        r_res_idx   <= r_s2_idx;
    end

    assign o_res = r_res;
    assign o_idx = r_res_idx;

endmodule

/* tb/tb_nearest_palette_color_yuv.sv */
typedef struct packed {
    logic                           found;
    logic [npc_pkg::LABEL_W-1:0]    label;
    logic [npc_pkg::COLOR_W-1:0]    color;
    logic [npc_pkg::SLOT_W-1:0]     slot;
    logic [npc_pkg::DIST_OUT_W-1:0] distance;
} t_answer;

class t_palette_model;
    bit [npc_pkg::LABEL_W-1:0] labels [npc_pkg::PALETTE_DEPTH];
    bit [npc_pkg::COLOR_W-1:0] colors [npc_pkg::PALETTE_DEPTH];
    int               count;
    t_answer          pending_answers [$];
    int               errors;
    int               n_clear;
    int               n_append;
    int               n_dropped;
    int               n_nop;
    int               n_query;
    int               n_empty;
    int               n_saturated;

    static function longint unsigned yuv_dist_sq(bit [npc_pkg::COLOR_W-1:0] a,
                                                 bit [npc_pkg::COLOR_W-1:0] b);
        longint dr, dg, db, y, u, v;
        dr = longint'(a[23:16]) - longint'(b[23:16]);
        dg = longint'(a[15:8]) - longint'(b[15:8]);
        db = longint'(a[7:0]) - longint'(b[7:0]);
        y  = 4899 * dr + 9617 * dg + 1868 * db;
        u  = -2411 * dr - 4733 * dg + 7143 * db;
        v  = 10076 * dr - 8438 * dg - 1639 * db;
        return y * y + u * u + v * v;
    endfunction

    function void note_command(npc_pkg::t_mode m, bit [npc_pkg::LABEL_W-1:0] lbl,
                               bit [npc_pkg::COLOR_W-1:0] ecol,
                               bit [npc_pkg::COLOR_W-1:0] qcol);
        t_answer         ans;
        longint unsigned best_d;
        longint unsigned d;
        int              best;
        case (m)
            npc_pkg::MODE_CLEAR: begin
                count = 0;
                n_clear++;
            end
            npc_pkg::MODE_APPEND: begin
                n_append++;
                if (count < npc_pkg::PALETTE_DEPTH) begin
                    labels[count] = lbl;
                    colors[count] = ecol;
                    count++;
                end else begin
                    n_dropped++;
                end
            end
            npc_pkg::MODE_QUERY: begin
                n_query++;
                ans = '0;
                if (count == 0) begin
                    n_empty++;
                end else begin
                    best   = 0;
                    best_d = yuv_dist_sq(qcol, colors[0]);
                    for (int i = 1; i < count; i++) begin
                        d = yuv_dist_sq(qcol, colors[i]);
                        if (d < best_d) begin
                            best_d = d;
                            best   = i;
                        end
                    end
                    ans.found = 1'b1;
                    ans.label = labels[best];
                    ans.color = colors[best];
                    ans.slot  = best[npc_pkg::SLOT_W-1:0];
                    if (best_d > 64'hFF_FFFF_FFFF) begin
                        ans.distance = '1;
                        n_saturated++;
                    end else begin
                        ans.distance = best_d[npc_pkg::DIST_OUT_W-1:0];
                    end
                end
                pending_answers.push_back(ans);
            end
            default: begin
                n_nop++;
            end
        endcase
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function string show(t_answer a);
        return $sformatf("found=%0b label=%h color=%h slot=%0d dist=%h",
                         a.found, a.label, a.color, a.slot, a.distance);
    endfunction

    function void check_answer(t_answer got);
        t_answer want;
        if (pending_answers.size() == 0) begin
            flag($sformatf("unexpected result: %s", show(got)));
            return;
        end
        want = pending_answers.pop_front();
        if (got !== want) begin
            flag($sformatf("mismatch: expected %s, got %s", show(want), show(got)));
        end
    endfunction
endclass

module tb_nearest_palette_color_yuv;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUERY_CYCLES = 3 * npc_pkg::PALETTE_DEPTH + 20;
    localparam int STALL_LIMIT  = 8 * QUERY_CYCLES;
    localparam int RANDOM_ITEMS = 1300;

    logic i_clk;
    logic i_rst_n;

    npc_in_if  in_ch ();
    npc_out_if out_ch ();

    nearest_palette_color_yuv i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_palette_model palette;
    int             n_items;
    bit             tx_calm;
    int             quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic hold_off(int n);
        repeat (n) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
    endtask

    task automatic send(npc_pkg::t_mode m, bit [npc_pkg::LABEL_W-1:0] lbl,
                        bit [npc_pkg::COLOR_W-1:0] ecol, bit [npc_pkg::COLOR_W-1:0] qcol);
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= m;
        in_ch.entry_label <= lbl;
        in_ch.entry_color <= ecol;
        in_ch.query_color <= qcol;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        palette.note_command(m, lbl, ecol, qcol);
        if (m != npc_pkg::MODE_NOP) begin
            n_items++;
        end
        if (!tx_calm && $urandom_range(0, 99) < 35) begin
            hold_off(gap_len());
        end
    endtask

    task automatic drain();
        do begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end while (palette.pending_answers.size() != 0);
    endtask

    function automatic bit [npc_pkg::COLOR_W-1:0] pick_color();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (palette.count == 0 || r < 35) begin
            return npc_pkg::COLOR_W'($urandom);
        end
        k = $urandom_range(0, palette.count - 1);
        if (r < 45) begin
            return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
        end else if (r < 70) begin
            return palette.colors[k];
        end
        return palette.colors[k] ^ (npc_pkg::COLOR_W'($urandom) & 24'h070707);
    endfunction

    task automatic append_one();
        send(npc_pkg::MODE_APPEND, npc_pkg::LABEL_W'($urandom), pick_color(),
             npc_pkg::COLOR_W'($urandom));
    endtask

    task automatic query_one();
        send(npc_pkg::MODE_QUERY, npc_pkg::LABEL_W'($urandom), npc_pkg::COLOR_W'($urandom),
             pick_color());
    endtask

    task automatic fill_palette();
        while (palette.count < npc_pkg::PALETTE_DEPTH) begin
            append_one();
        end
        repeat ($urandom_range(1, 4)) append_one();
        repeat ($urandom_range(2, 4)) query_one();
    endtask

    // output side: random backpressure with calm stretches
    initial begin
        int stall_left;
        int calm_left;
        bit rx_calm;
        stall_left   = 0;
        calm_left    = 0;
        rx_calm      = 1'b0;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (calm_left == 0) begin
                rx_calm   = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 400);
            end
            calm_left--;
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
                stall_left = gap_len() - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            palette.check_answer({out_ch.found, out_ch.nearest_label, out_ch.nearest_color,
                                  out_ch.nearest_slot, out_ch.distance_squared});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_nearest_palette_color_yuv: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int k;
        palette           = new();
        quiet_cycles      = 0;
        n_items           = 0;
        tx_calm           = 1'b0;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.mode        = npc_pkg::MODE_NOP;
        in_ch.entry_label = '0;
        in_ch.entry_color = '0;
        in_ch.query_color = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(npc_pkg::MODE_QUERY, 16'h0000, 24'h000000, 24'h000000);
        send(npc_pkg::MODE_NOP, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send(npc_pkg::MODE_APPEND, 16'h0000, 24'h000000, 24'hFFFFFF);
        send(npc_pkg::MODE_APPEND, 16'hFFFF, 24'hFFFFFF, 24'h000000);
        send(npc_pkg::MODE_QUERY, 16'h5555, 24'h555555, 24'hFFFFFF);
        send(npc_pkg::MODE_QUERY, 16'hAAAA, 24'hAAAAAA, 24'h000000);
        send(npc_pkg::MODE_QUERY, 16'h0000, 24'h000000, 24'h808080);
        send(npc_pkg::MODE_APPEND, 16'h1234, 24'hFF0000, 24'h000000);
        send(npc_pkg::MODE_APPEND, 16'h5678, 24'h00FF00, 24'h000000);
        send(npc_pkg::MODE_APPEND, 16'h9ABC, 24'h0000FF, 24'h000000);
        send(npc_pkg::MODE_QUERY, 16'h0000, 24'h000000, 24'hF01010);
        send(npc_pkg::MODE_QUERY, 16'h0000, 24'h000000, 24'h0000FF);
        // duplicate of the first entry: lowest slot must win
        send(npc_pkg::MODE_APPEND, 16'hABCD, 24'h000000, 24'h000000);
        send(npc_pkg::MODE_QUERY, 16'h0000, 24'h000000, 24'h000000);
        send(npc_pkg::MODE_QUERY, 16'h0000, 24'h000000, 24'h010101);
        send(npc_pkg::MODE_CLEAR, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send(npc_pkg::MODE_QUERY, 16'h0000, 24'h000000, 24'h7F7F7F);
        send(npc_pkg::MODE_APPEND, 16'h0F0F, 24'h123456, 24'h000000);
        send(npc_pkg::MODE_QUERY, 16'h0000, 24'h000000, 24'hEDCBA9);
        send(npc_pkg::MODE_NOP, 16'h0000, 24'h000000, 24'h000000);
        send(npc_pkg::MODE_CLEAR, 16'h0000, 24'h000000, 24'h000000);
        send(npc_pkg::MODE_QUERY, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        drain();

        n_items = 0;
        fill_palette();
        while (n_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                tx_calm = ~tx_calm;
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                if ($urandom_range(0, 1) == 0) begin
                    send(npc_pkg::MODE_CLEAR, npc_pkg::LABEL_W'($urandom),
                         npc_pkg::COLOR_W'($urandom), npc_pkg::COLOR_W'($urandom));
                end
                k = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                repeat (k) append_one();
                repeat ($urandom_range(1, 6)) query_one();
            end else if (r < 62) begin
                fill_palette();
            end else if (r < 80) begin
                repeat ($urandom_range(1, 8)) query_one();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send(npc_pkg::t_mode'($urandom_range(0, 3)), npc_pkg::LABEL_W'($urandom),
                         npc_pkg::COLOR_W'($urandom), npc_pkg::COLOR_W'($urandom));
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                drain();
            end
        end

        drain();
        hold_off(QUERY_CYCLES);
        if (palette.pending_answers.size() != 0) begin
            palette.flag($sformatf("%0d results never arrived", palette.pending_answers.size()));
        end
        $display("run covered %0d clears, %0d appends (%0d dropped when full), %0d no-ops",
                 palette.n_clear, palette.n_append, palette.n_dropped, palette.n_nop);
        $display("run covered %0d queries, %0d on empty palette, %0d saturated, %0d errors",
                 palette.n_query, palette.n_empty, palette.n_saturated, palette.errors);
        if (palette.errors == 0) begin
            $display("tb_nearest_palette_color_yuv: done, clean");
        end else begin
            $display("tb_nearest_palette_color_yuv: done, errors");
        end
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/npc_pkg.sv
hw/rtl/npc_if.sv
hw/rtl/npc_ram.sv
hw/rtl/npc_dist.sv
hw/rtl/nearest_palette_color_yuv.sv
tb/tb_nearest_palette_color_yuv.sv
